// ----- src/raw_frame_to_rgba8888_macros.svh -----
// Assertion macros for the raw frame to RGBA8888 converter.
// Included by the top level; no other dependencies.
`ifndef RAW_FRAME_TO_RGBA8888_MACROS_SVH
`define RAW_FRAME_TO_RGBA8888_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define RF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("raw_frame_to_rgba8888 assertion failed");
// Next-cycle implication, disabled during reset.
`define RF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("raw_frame_to_rgba8888 assertion failed");
`else
`define RF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RF_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- src/rf2rgba_pkg.sv -----
// Package for the raw frame to RGBA8888 converter: format and status codes,
// bytes-per-pixel lookup and the 5/6-bit channel expansion. No dependencies.
package rf2rgba_pkg;

   // Result status codes.
   localparam logic [1:0] ST_PIXEL      = 2'd0;
   localparam logic [1:0] ST_BAD_FORMAT = 2'd1;
   localparam logic [1:0] ST_BAD_DIMS   = 2'd2;
   localparam logic [1:0] ST_INCOMPLETE = 2'd3;

   // Pixel format codes from the header.
   localparam logic [2:0] FMT_RGBA8888 = 3'd1;
   localparam logic [2:0] FMT_RGBX8888 = 3'd2;
   localparam logic [2:0] FMT_RGB888   = 3'd3;
   localparam logic [2:0] FMT_RGB565   = 3'd4;
   localparam logic [2:0] FMT_BGRA8888 = 3'd5;

   // Reciprocal constants: x*255/31 == (x*8625630) >> 20 for 5-bit x,
   // x*255/63 == (x*4244475) >> 20 for 6-bit x.
   localparam logic [23:0] EXP5_MULT = 24'd8625630;
   localparam logic [23:0] EXP6_MULT = 24'd4244475;

   typedef logic [2:0] bpp_type;

   // Input bytes per pixel; zero for an unknown format.
   function automatic bpp_type fmt_bpp(input logic [2:0] fmt);
      bpp_type n;
      case (fmt)
         FMT_RGBA8888, FMT_RGBX8888, FMT_BGRA8888: n = 3'd4;
         FMT_RGB888:                               n = 3'd3;
         FMT_RGB565:                               n = 3'd2;
         default:                                  n = 3'd0;
      endcase
      return n;
   endfunction

   // Widen a 5-bit channel to 8 bits, truncating.
   function automatic logic [7:0] expand5(input logic [4:0] x);
      logic [28:0] p;
      p = {24'd0, x} * {5'd0, EXP5_MULT};
      return p[27:20];
   endfunction

   // Widen a 6-bit channel to 8 bits, truncating.
   function automatic logic [7:0] expand6(input logic [5:0] x);
      logic [29:0] p;
      p = {24'd0, x} * {6'd0, EXP6_MULT};
      return p[27:20];
   endfunction

endpackage

// ----- src/raw_frame_to_rgba8888.sv -----
// Raw capture frame to RGBA8888 converter, top level.
// Depends on rf2rgba_pkg and raw_frame_to_rgba8888_macros.svh.
//
//  channel  direction  ports                 payload
//  req      in         req_t*                tdata: data byte; tuser: frame start
//  rsp      out        rsp_t*                tdata: RGBA + width/height; tuser: status;
//                                            tlast: last pixel of frame
//
// One input item is taken per cycle; its result, if any, appears in the output
// register on the next cycle, set by the single header/pixel update stage.
// The output register lets a new item in while a result waits to be taken;
// input stalls only when that register is full and rsp_tready is low.
// Synchronous active-high reset returns the parser to idle with no result pending.
`include "raw_frame_to_rgba8888_macros.svh"

module raw_frame_to_rgba8888
   import rf2rgba_pkg::*;
#(
   parameter int DIM_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [47:32] frame_width,
                                    // [63:48] frame_height
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last_pixel
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_PIXELS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   // Parser state.
   logic [1:0]          phase_ff, phase_in;
   logic [3:0]          hcnt_ff, hcnt_in;
   logic [31:0]         hshift_ff, hshift_in;
   logic [31:0]         width_ff, width_in;
   logic [31:0]         height_ff, height_in;
   logic [2:0]          fmt_ff, fmt_in;
   logic [23:0]         pbytes_ff, pbytes_in;
   logic [1:0]          bip_ff, bip_in;
   logic [DIM_BITS-1:0] col_left_ff, col_left_in;
   logic [DIM_BITS-1:0] row_left_ff, row_left_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;

   logic       accept;
   logic       start;
   logic [7:0] din;
   logic [1:0] ph_eff;
   logic [3:0] hcnt_eff;
   logic [31:0] hshift_eff;
   logic       emit;
   logic [1:0] emit_status;
   logic       emit_last;
   logic [7:0] red, green, blue, alpha;
   bpp_type    bpp;
   logic [7:0] p0, p1, p2;
   logic [15:0] v565;
   logic       fmt_ok;
   logic       dims_bad;
   logic       last_pix;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign start      = req_tuser;
   assign din        = req_tdata;
   assign bpp        = fmt_bpp(fmt_ff);

   // Pixel byte selection by input pixel size.
   always_comb begin
      p0 = pbytes_ff[7:0];
      p1 = (bpp == 3'd2) ? din : pbytes_ff[15:8];
      if (bpp == 3'd4) begin
         p2 = pbytes_ff[23:16];
      end else if (bpp == 3'd3) begin
         p2 = din;
      end else begin
         p2 = 8'd0;
      end
      v565 = {p1, p0};
   end

   // Channel mapping per format.
   always_comb begin
      case (fmt_ff)
         FMT_RGBA8888: begin
            red = p0; green = p1; blue = p2; alpha = din;
         end
         FMT_BGRA8888: begin
            red = p2; green = p1; blue = p0; alpha = din;
         end
         FMT_RGBX8888, FMT_RGB888: begin
            red = p0; green = p1; blue = p2; alpha = 8'hFF;
         end
         default: begin
            red   = expand5(v565[15:11]);
            green = expand6(v565[10:5]);
            blue  = expand5(v565[4:0]);
            alpha = 8'hFF;
         end
      endcase
   end

   // On the twelfth header byte the format word is this byte over the upper
   // three bytes already shifted in.
   assign fmt_ok   = (din == 8'd0) && (hshift_ff[31:11] == 21'd0) &&
                     (fmt_bpp(hshift_ff[10:8]) != 3'd0);
   assign dims_bad = (width_ff == 32'd0) || (height_ff == 32'd0) ||
                     (|width_ff[31:DIM_BITS]) || (|height_ff[31:DIM_BITS]);
   assign last_pix = (col_left_ff == DIM_BITS'(1)) && (row_left_ff == DIM_BITS'(1));

   // Per-item state update and result selection.
   always_comb begin
      phase_in    = phase_ff;
      hcnt_in     = hcnt_ff;
      hshift_in   = hshift_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      fmt_in      = fmt_ff;
      pbytes_in   = pbytes_ff;
      bip_in      = bip_ff;
      col_left_in = col_left_ff;
      row_left_in = row_left_ff;
      emit        = 1'b0;
      emit_status = ST_PIXEL;
      emit_last   = 1'b0;

      // A frame start aborts any frame in progress and restarts the header.
      ph_eff     = phase_ff;
      hcnt_eff   = hcnt_ff;
      hshift_eff = hshift_ff;
      if (start) begin
         if (phase_ff == PH_HEADER || phase_ff == PH_PIXELS) begin
            emit        = 1'b1;
            emit_status = ST_INCOMPLETE;
         end
         ph_eff      = PH_HEADER;
         hcnt_eff    = 4'd0;
         hshift_eff  = 32'd0;
         width_in    = 32'd0;
         height_in   = 32'd0;
         fmt_in      = 3'd0;
         pbytes_in   = 24'd0;
         bip_in      = 2'd0;
         col_left_in = '0;
         row_left_in = '0;
      end
      phase_in = ph_eff;

      case (ph_eff)
         PH_HEADER: begin
            hshift_in = {din, hshift_eff[31:8]};
            hcnt_in   = hcnt_eff + 4'd1;
            if (hcnt_in == 4'd4) begin
               width_in = hshift_in;
            end else if (hcnt_in == 4'd8) begin
               height_in = hshift_in;
            end else if (hcnt_in == 4'd12) begin
               // Format is checked before dimensions.
               if (!fmt_ok) begin
                  phase_in    = PH_DONE;
                  emit        = 1'b1;
                  emit_status = ST_BAD_FORMAT;
               end else begin
                  fmt_in = hshift_in[2:0];
                  if (dims_bad) begin
                     phase_in    = PH_DONE;
                     emit        = 1'b1;
                     emit_status = ST_BAD_DIMS;
                  end else begin
                     col_left_in = width_ff[DIM_BITS-1:0];
                     row_left_in = height_ff[DIM_BITS-1:0];
                     bip_in      = 2'd0;
                     pbytes_in   = 24'd0;
                     phase_in    = PH_PIXELS;
                  end
               end
            end
         end
         PH_PIXELS: begin
            if ({1'b0, bip_ff} + 3'd1 < bpp) begin
               // Collect another byte of the current pixel.
               case (bip_ff)
                  2'd0:    pbytes_in[7:0]   = din;
                  2'd1:    pbytes_in[15:8]  = din;
                  2'd2:    pbytes_in[23:16] = din;
                  default: pbytes_in        = pbytes_ff;
               endcase
               bip_in = bip_ff + 2'd1;
            end else begin
               // Pixel complete: emit it and step the column/row counters.
               emit        = 1'b1;
               emit_status = ST_PIXEL;
               emit_last   = last_pix;
               bip_in      = 2'd0;
               pbytes_in   = 24'd0;
               if (col_left_ff == DIM_BITS'(1)) begin
                  col_left_in = width_ff[DIM_BITS-1:0];
                  row_left_in = row_left_ff - DIM_BITS'(1);
               end else begin
                  col_left_in = col_left_ff - DIM_BITS'(1);
               end
               if (last_pix) begin
                  phase_in = PH_DONE;
               end
            end
         end
         default: begin
            phase_in = ph_eff;
         end
      endcase
   end

   // Result payload; stored width and height are those before any restart.
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      if (accept && emit) begin
         out_valid_in  = 1'b1;
         out_status_in = emit_status;
         out_last_in   = emit_last;
         out_data_in[47:32] = width_ff[15:0];
         out_data_in[63:48] = height_ff[15:0];
         if (emit_status == ST_PIXEL) begin
            out_data_in[31:0] = {alpha, blue, green, red};
         end else begin
            out_data_in[31:0] = 32'd0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hcnt_ff      <= 4'd0;
         hshift_ff    <= 32'd0;
         width_ff     <= 32'd0;
         height_ff    <= 32'd0;
         fmt_ff       <= 3'd0;
         pbytes_ff    <= 24'd0;
         bip_ff       <= 2'd0;
         col_left_ff  <= '0;
         row_left_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            hcnt_ff     <= hcnt_in;
            hshift_ff   <= hshift_in;
            width_ff    <= width_in;
            height_ff   <= height_in;
            fmt_ff      <= fmt_in;
            pbytes_ff   <= pbytes_in;
            bip_ff      <= bip_in;
            col_left_ff <= col_left_in;
            row_left_ff <= row_left_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

   // Error results carry no color and never end a frame.
   `RF_ASSERT_IMP(a_err_clean, clock, reset, out_valid_ff && (out_status_ff != ST_PIXEL),
                  (out_data_ff[31:0] == 32'd0) && !out_last_ff)
   // The pixel counters never run out while pixels are still expected.
   `RF_ASSERT_IMP(a_cnt_live, clock, reset, phase_ff == PH_PIXELS,
                  (col_left_ff != '0) && (row_left_ff != '0) && ({1'b0, bip_ff} < bpp))
   // A waiting result blocks input only while it is not taken.
   `RF_ASSERT_IMP(a_no_overrun, clock, reset, out_valid_ff && !rsp_tready, !req_tready)
   // The final pixel always leaves the parser in the done state.
   `RF_ASSERT_NXT(a_last_done, clock, reset, accept && emit && emit_last, phase_ff == PH_DONE)

endmodule
